// File: rtl/tfr_pkg.sv
// Package: types and constants shared by the tag frame receiver files.
`default_nettype none

package tfr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] index_type;
   typedef logic [4:0] count_type;

   // frame delimiters
   localparam byte_type OPEN_BYTE  = 8'h00;
   localparam byte_type CLOSE_BYTE = 8'hFF;

   // a store that takes the fill count above this abandons the frame
   localparam logic [5:0] FILL_LIMIT = 6'd25;

   // fill counts (stored bytes, closing byte excluded) of the known layouts
   localparam count_type FILL_LEN_14 = 5'd13;
   localparam count_type FILL_LEN_17 = 5'd16;
   localparam count_type FILL_LEN_20 = 5'd19;

   // chain taps: newest byte sits in cell 0
   localparam int TAP_SHORT = 9;
   localparam int TAP_LONG  = 12;
   localparam int CHAIN_LEN = TAP_LONG + 1;

   // ID bytes a 14-byte frame carries
   localparam index_type SHORT_ID_BYTES = 4'd8;

   // last ID byte index for each id_length_sel setting
   localparam index_type LAST_IDX_8  = 4'd7;
   localparam index_type LAST_IDX_12 = 4'd11;

   // emission layout codes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ZERO  = 2'd0;
   localparam mode_type MODE_SHORT = 2'd1;
   localparam mode_type MODE_LONG  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/tfr_if.sv
// Interfaces: request and response channels of the tag frame receiver.
`default_nettype none

interface tfr_req_if;
   import tfr_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfr_rsp_if;
   import tfr_pkg::*;

   logic      valid;
   logic      ready;
   byte_type  id_byte;
   index_type byte_index;
   logic      status;
   logic      last;

   modport source (output valid, output id_byte, output byte_index, output status,
                   output last, input ready);
   modport sink   (input valid, input id_byte, input byte_index, input status,
                   input last, output ready);
endinterface

`default_nettype wire

// File: rtl/tag_frame_receiver.sv
// Top level: tag frame receiver built on a chain of byte cells.
//
// Takes one serial byte per request. A 0x00 byte while idle opens a frame,
// every byte other than 0xFF is stored, and 0xFF closes it; a frame that
// stores more than 25 bytes is dropped. At the close the frame is good
// when all stored bytes sum to zero modulo 256 (the last stored byte is
// the two's complement of the others) and at least two bytes were stored;
// otherwise, and for a 0xFF while idle, one error response (status 1,
// last 1) is sent. A good frame sends 8 or 12 ID byte responses, chosen
// by id_length_sel (reset 1 = 12). While the ID bytes are sent no request
// is taken. A request is taken only while the response register is free
// or being emptied, so the response side's stalls set the rate. Stored
// bytes move through a 13-cell shift chain, newest in cell 0; during the
// ID burst the chain keeps shifting so that successive ID bytes reach one
// fixed read tap.
`default_nettype none

module tag_frame_receiver (
   input  wire logic  clock,
   input  wire logic  reset,
   tfr_req_if.sink    req_if,
   tfr_rsp_if.source  rsp_if,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data
);
   import tfr_pkg::*;

   localparam logic ST_COLLECT = 1'b0;
   localparam logic ST_EMIT    = 1'b1;

   // control state
   logic      state_ff, state_in;
   count_type fill_count_ff, fill_count_in;
   byte_type  running_sum_ff, running_sum_in;
   mode_type  mode_ff, mode_in;
   index_type idx_ff, idx_in;
   logic      id_length_sel_ff, id_length_sel_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // response payload
   byte_type  rsp_id_byte_ff, rsp_id_byte_in;
   index_type rsp_byte_index_ff, rsp_byte_index_in;
   logic      rsp_status_ff, rsp_status_in;
   logic      rsp_last_ff, rsp_last_in;

   // chain
   byte_type  cell_q [CHAIN_LEN];
   logic      shift_en;
   byte_type  shift_byte;

   logic       out_free;
   logic       accept;
   logic       is_close;
   logic       store;
   logic       close;
   logic       frame_bad;
   logic [5:0] fill_inc;
   logic       emit_step;
   logic       last_item;
   byte_type   emit_byte;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_COLLECT) && out_free;
   assign accept       = req_if.valid && req_if.ready;
   assign is_close     = (req_if.rx_byte == CLOSE_BYTE);

   // bytes other than the opener and 0xFF are ignored while no frame is open
   assign store = accept && !is_close &&
                  ((fill_count_ff != '0) || (req_if.rx_byte == OPEN_BYTE));
   assign close = accept && is_close;

   // sum of all stored bytes zero <=> last byte is minus the sum of the rest
   assign frame_bad = (fill_count_ff < 5'd2) || (running_sum_ff != '0);
   assign fill_inc  = {1'b0, fill_count_ff} + 6'd1;

   assign emit_step = (state_ff == ST_EMIT) && out_free;
   assign last_item = (idx_ff == (id_length_sel_ff ? LAST_IDX_12 : LAST_IDX_8));

   // chain moves on every stored byte and every ID byte sent; zeros fill in
   assign shift_en   = store || emit_step;
   assign shift_byte = store ? req_if.rx_byte : '0;

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
      if (i == 0) begin : g_head
         tfr_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .byte_in  (shift_byte),
            .byte_out (cell_q[i])
         );
      end else begin : g_body
         tfr_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .byte_in  (cell_q[i-1]),
            .byte_out (cell_q[i])
         );
      end
   end

   // after k shifts the tap holds the byte for ID index k
   always_comb begin
      case (mode_ff)
         MODE_SHORT: emit_byte = (idx_ff < SHORT_ID_BYTES) ? cell_q[TAP_SHORT] : '0;
         MODE_LONG:  emit_byte = cell_q[TAP_LONG];
         default:    emit_byte = '0;
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      fill_count_in     = fill_count_ff;
      running_sum_in    = running_sum_ff;
      mode_in           = mode_ff;
      idx_in            = idx_ff;
      id_length_sel_in  = id_length_sel_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_id_byte_in    = rsp_id_byte_ff;
      rsp_byte_index_in = rsp_byte_index_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_wr_en) begin
         id_length_sel_in = csr_wr_data;
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (store) begin
         if (fill_inc > FILL_LIMIT) begin
            // overflow: drop the frame
            fill_count_in  = '0;
            running_sum_in = '0;
         end else begin
            fill_count_in  = fill_inc[4:0];
            running_sum_in = running_sum_ff + req_if.rx_byte;
         end
      end

      if (close) begin
         fill_count_in  = '0;
         running_sum_in = '0;
         if (frame_bad) begin
            rsp_valid_in      = 1'b1;
            rsp_id_byte_in    = '0;
            rsp_byte_index_in = '0;
            rsp_status_in     = 1'b1;
            rsp_last_in       = 1'b1;
         end else begin
            state_in = ST_EMIT;
            idx_in   = '0;
            if (fill_count_ff == FILL_LEN_14) begin
               mode_in = MODE_SHORT;
            end else if ((fill_count_ff == FILL_LEN_17) ||
                         (fill_count_ff == FILL_LEN_20)) begin
               mode_in = MODE_LONG;
            end else begin
               mode_in = MODE_ZERO;
            end
         end
      end

      if (emit_step) begin
         rsp_valid_in      = 1'b1;
         rsp_id_byte_in    = emit_byte;
         rsp_byte_index_in = idx_ff;
         rsp_status_in     = 1'b0;
         rsp_last_in       = last_item;
         if (last_item) begin
            state_in = ST_COLLECT;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_COLLECT;
         fill_count_ff    <= '0;
         running_sum_ff   <= '0;
         mode_ff          <= MODE_ZERO;
         idx_ff           <= '0;
         id_length_sel_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         fill_count_ff    <= fill_count_in;
         running_sum_ff   <= running_sum_in;
         mode_ff          <= mode_in;
         idx_ff           <= idx_in;
         id_length_sel_ff <= id_length_sel_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_byte_ff    <= rsp_id_byte_in;
      rsp_byte_index_ff <= rsp_byte_index_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.id_byte    = rsp_id_byte_ff;
   assign rsp_if.byte_index = rsp_byte_index_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.last       = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/tfr_cell.sv
// One cell of the frame byte chain: a byte register loaded from its neighbour.
`default_nettype none

module tfr_cell (
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire tfr_pkg::byte_type byte_in,
   output tfr_pkg::byte_type     byte_out
);
   import tfr_pkg::*;

   byte_type data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= byte_in;
      end
   end

   assign byte_out = data_ff;

endmodule

`default_nettype wire
